>>> sv/udiv_pkg.sv
// shared constants for the unsigned restoring divider
package udiv_pkg;

    // operand and quotient field width on the stream ports
    localparam int FIELD_W      = 64;
    // default datapath width, legal range 8 to 64
    localparam int DATA_WIDTH_DEF = 64;
    // input tdata carries dividend then divisor
    localparam int IN_TDATA_W   = 2 * FIELD_W;
    // output tdata carries the quotient
    localparam int OUT_TDATA_W  = FIELD_W;
    // output tuser carries the divide-by-zero flag
    localparam int OUT_TUSER_W  = 1;

endpackage

>>> sv/udiv_stage.sv
// one restoring division step with its pipeline register
module udiv_stage #(
    parameter int DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_nq,
    input  logic [DATA_WIDTH-1:0] i_den,
    input  logic                  i_dz,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_nq,
    output logic [DATA_WIDTH-1:0] o_den,
    output logic                  o_dz
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_nq;
    logic [DATA_WIDTH-1:0] r_den;
    logic                  r_dz;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  take;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_nq;

    // remainder shifted left with the next dividend bit, one bit wider
    always_comb begin
        shifted = {i_rem, i_nq[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, i_den};
        take    = ~diff[DATA_WIDTH];
        n_rem   = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        n_nq    = {i_nq[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
            r_dz  <= i_dz;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_dz    = r_dz;

endmodule

>>> sv/unsigned_restoring_divider_unit.sv
// top level of the pipelined unsigned restoring divider
// path: input register, one step stage per quotient bit, then the output register
// throughput: one item per cycle while the pipe is not frozen, one division step per pipeline stage
// stall: a two-entry output buffer holds results; the pipe freezes only when both are full
// reset: i_rst_n synchronous active low clears all valid bits, payload is not reset
// a zero divisor returns quotient zero with the divide-by-zero flag set
module unsigned_restoring_divider_unit #(
    parameter int DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [63:0] dividend, [127:64] divisor
    input  logic [udiv_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [63:0] quotient
    output logic [udiv_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [0] divide_by_zero
    output logic [udiv_pkg::OUT_TUSER_W-1:0]    o_m_tuser
);

    localparam int FW = udiv_pkg::FIELD_W;

    // pipeline enable: the whole pipe moves unless the output buffer is full
    logic en;

    // stage 0 is the input register, stages 1..DATA_WIDTH do one step each
    logic                  p_valid [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] p_rem   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] p_nq    [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] p_den   [DATA_WIDTH+1];
    logic                  p_dz    [DATA_WIDTH+1];

    logic                  r_in_valid;
    logic [DATA_WIDTH-1:0] r_in_num;
    logic [DATA_WIDTH-1:0] r_in_den;
    logic                  r_in_dz;

    logic [DATA_WIDTH-1:0] in_num;
    logic [DATA_WIDTH-1:0] in_den;

    // output register and skid entry
    logic          r_out_valid, n_out_valid;
    logic [FW-1:0] r_out_q,     n_out_q;
    logic          r_out_dz,    n_out_dz;
    logic          r_skid_valid, n_skid_valid;
    logic [FW-1:0] r_skid_q,     n_skid_q;
    logic          r_skid_dz,    n_skid_dz;

    logic          emit;
    logic          out_take;
    logic          out_free;
    logic [FW-1:0] pipe_q;

    assign en         = ~r_skid_valid;
    assign o_s_tready = en;

    // bits above the datapath width are ignored
    assign in_num = i_s_tdata[DATA_WIDTH-1:0];
    assign in_den = i_s_tdata[FW+DATA_WIDTH-1:FW];

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_num <= in_num;
            r_in_den <= in_den;
            r_in_dz  <= (in_den == '0);
        end
    end

    // partial remainder starts at zero
    assign p_valid[0] = r_in_valid;
    assign p_rem[0]   = '0;
    assign p_nq[0]    = r_in_num;
    assign p_den[0]   = r_in_den;
    assign p_dz[0]    = r_in_dz;

    // one step per stage, most significant quotient bit first
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        udiv_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (p_valid[g]),
            .i_rem   (p_rem[g]),
            .i_nq    (p_nq[g]),
            .i_den   (p_den[g]),
            .i_dz    (p_dz[g]),
            .o_valid (p_valid[g+1]),
            .o_rem   (p_rem[g+1]),
            .o_nq    (p_nq[g+1]),
            .o_den   (p_den[g+1]),
            .o_dz    (p_dz[g+1])
        );
    end

    // after the last step the shift register holds the whole quotient
    assign pipe_q   = p_dz[DATA_WIDTH] ? '0 : FW'(p_nq[DATA_WIDTH]);
    assign emit     = en & p_valid[DATA_WIDTH];
    assign out_take = r_out_valid & i_m_tready;
    assign out_free = ~r_out_valid | i_m_tready;

    // output register with skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_q      = r_out_q;
        n_out_dz     = r_out_dz;
        n_skid_valid = r_skid_valid;
        n_skid_q     = r_skid_q;
        n_skid_dz    = r_skid_dz;
        if (r_skid_valid) begin
            // pipe is frozen, drain the skid entry first
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_q      = r_skid_q;
                n_out_dz     = r_skid_dz;
                n_skid_valid = 1'b0;
            end
        end else if (emit) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_q     = pipe_q;
                n_out_dz    = p_dz[DATA_WIDTH];
            end else begin
                n_skid_valid = 1'b1;
                n_skid_q     = pipe_q;
                n_skid_dz    = p_dz[DATA_WIDTH];
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_q   <= n_out_q;
        r_out_dz  <= n_out_dz;
        r_skid_q  <= n_skid_q;
        r_skid_dz <= n_skid_dz;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_q;
    assign o_m_tuser[0] = r_out_dz;

`ifndef SYNTHESIS
    // the skid entry is only ever occupied behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // a divide-by-zero result always carries a zero quotient
    a_dz_zero_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("divide by zero with nonzero quotient");

    // input side backs off only after the output was stalled
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("input stalled without output back pressure");

    // quotient bits above the datapath width stay zero
    a_q_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata >> DATA_WIDTH) == '0))
        else $error("quotient exceeds datapath width");
`endif

endmodule
